// File: rtl/bra_pkg.sv
// bitmap run allocator package: status and command codes, controller states
// no dependencies
`default_nettype none
package bra_pkg;
   localparam int TABLE_BITS_DEF = 4096;
   localparam int WORD_BITS_DEF  = 64;

   typedef enum logic [2:0] {
      CMD_SET   = 3'd0,
      CMD_CLR   = 3'd1,
      CMD_FIND  = 3'd2,
      CMD_FRUN  = 3'd3,
      CMD_MARK  = 3'd4,
      CMD_CRUN  = 3'd5,
      CMD_CHECK = 3'd6,
      CMD_BAD   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NONE  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_WAIT,
      S_WORK,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

// File: rtl/bra_mem.sv
// bitmap word memory, one write port and one registered read port
// depends on nothing
`default_nettype none
module bra_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/bitmap_run_allocator_core.sv
// bitmap run allocator top level: controller, word scan, memory
// depends on bra_pkg and bra_mem
// sequence: S_READ, then S_WAIT and S_WORK for each word visited, then S_DONE; bit commands visit
// one word, range errors go from S_READ straight to S_DONE; one command in flight
// reset: a clearing pass writes every word free, busy high;
// next command taken in the cycle after the response strobe; the receiver cannot stall
`default_nettype none
module bitmap_run_allocator_core #(
   parameter int TABLE_BITS = bra_pkg::TABLE_BITS_DEF,
   parameter int WORD_BITS  = bra_pkg::WORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [2:0]  req_command,
   input  wire logic [11:0] req_unit_index,
   input  wire logic [12:0] req_run_length,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [9:0]  csr_data,
   output      logic        rsp_strobe,
   output      logic [1:0]  rsp_status,
   output      logic [11:0] rsp_position
);
   import bra_pkg::*;

   localparam int WORDS = (TABLE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BW    = $clog2(WORD_BITS);
   localparam int LW    = BW + 1;
   localparam int UW    = $clog2(TABLE_BITS + 1) + 1;

   state_type  state_ff, state_in;
   logic [9:0] bytes_ff;
   logic [2:0] cmd_ff;
   logic [UW-1:0] idx_ff, len_ff, end_ff, used_ff;
   logic [UW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic [AW-1:0] clr_ff;
   logic [1:0] st_ff, st_in;
   logic [11:0] pos_ff, pos_in;
   logic       fin;
   logic [WORD_BITS-1:0] rd_data, word_in;
   logic       wr_en;
   logic [AW-1:0] wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [UW-1:0] used_now, idx_x, len_x, end_x;
   logic [LW-1:0] last_used [WORD_BITS];
   logic [UW-1:0] run_cnt [WORD_BITS];

   always_comb begin
      used_now = UW'({bytes_ff, 3'b000});
      if (used_now > UW'(TABLE_BITS)) used_now = UW'(TABLE_BITS);
      idx_x = UW'(req_unit_index);
      len_x = UW'(req_run_length);
      end_x = idx_x + len_x;
   end

   bra_mem #(.DEPTH(WORDS), .WIDTH(WORD_BITS)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(waddr_ff), .rd_data(rd_data));

   // free run length ending at each unit, from a prefix max of used positions
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         last_used[b] = rd_data[b] ? LW'(b + 1) : '0;
      end
      for (int s = 1; s < WORD_BITS; s = s * 2) begin
         for (int b = WORD_BITS - 1; b >= s; b--) begin
            if (last_used[b - s] > last_used[b]) last_used[b] = last_used[b - s];
         end
      end
      for (int b = 0; b < WORD_BITS; b++) begin
         if (last_used[b] == '0) run_cnt[b] = cnt_ff + UW'(b + 1);
         else run_cnt[b] = UW'(b + 1) - UW'(last_used[b]);
      end
   end

   // word scan: walk the current word one unit at a time in a fixed loop
   always_comb begin
      logic [UW-1:0] u;
      logic bit_used;
      logic inr;
      u = '0;
      bit_used = 1'b0;
      inr = 1'b0;
      fin = 1'b0;
      st_in = st_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      word_in = rd_data;
      for (int b = 0; b < WORD_BITS; b++) begin
         u = UW'({waddr_ff, BW'(0)}) + UW'(b);
         bit_used = rd_data[b];
         if (!fin) begin
            case (cmd_ff)
               CMD_SET, CMD_CLR: begin
                  if (u == idx_ff) word_in[b] = (cmd_ff == CMD_SET);
               end
               CMD_FIND: begin
                  if (u >= used_ff) begin
                     fin = 1'b1;
                  end else if (!bit_used) begin
                     fin = 1'b1; st_in = ST_OK; pos_in = 12'(u);
                  end
               end
               CMD_FRUN: begin
                  if (u >= used_ff) begin
                     fin = 1'b1;
                  end else if (run_cnt[b] >= len_ff) begin
                     fin = 1'b1; st_in = ST_OK; pos_in = 12'(u + UW'(1) - len_ff);
                  end
               end
               default: begin
                  inr = (u >= idx_ff) && (u < end_ff);
                  if (inr) begin
                     if (cmd_ff == CMD_CHECK) begin
                        if (bit_used) begin fin = 1'b1; st_in = ST_NONE; end
                     end else begin
                        word_in[b] = (cmd_ff == CMD_MARK);
                     end
                  end
               end
            endcase
         end
      end
      if (cmd_ff == CMD_FRUN) cnt_in = run_cnt[WORD_BITS-1];
   end

   logic last_word;
   always_comb begin
      last_word = (waddr_ff == AW'(WORDS - 1));
      case (cmd_ff)
         CMD_SET, CMD_CLR: last_word = 1'b1;
         CMD_FIND, CMD_FRUN:
            last_word = last_word ||
                        (UW'({waddr_ff, BW'(0)}) + UW'(WORD_BITS) >= used_ff);
         default:
            last_word = last_word ||
                        (UW'({waddr_ff, BW'(0)}) + UW'(WORD_BITS) >= end_ff);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == AW'(WORDS - 1)) state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_READ;
         S_READ:  state_in = (st_ff == ST_RANGE && cmd_ff != CMD_BAD) ||
                             cmd_ff == CMD_BAD || used_ff == '0 ? S_DONE : S_WAIT;
         S_WAIT:  state_in = S_WORK;
         S_WORK:  state_in = (fin || last_word) ? S_DONE : S_WAIT;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != S_IDLE);
      csr_ready = !busy;
      rsp_strobe = (state_ff == S_DONE);
      rsp_status = st_ff;
      rsp_position = (st_ff == ST_OK) ? pos_ff : 12'd0;
      wr_en = (state_ff == S_CLEAR) ||
              (state_ff == S_WORK && cmd_ff != CMD_FIND && cmd_ff != CMD_FRUN &&
               cmd_ff != CMD_CHECK);
      wr_addr = (state_ff == S_CLEAR) ? clr_ff : waddr_ff;
      wr_data = (state_ff == S_CLEAR) ? '0 : word_in;
      waddr_in = waddr_ff;
      if (state_ff == S_WORK && !(fin || last_word)) waddr_in = waddr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         bytes_ff <= 10'd512;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr_valid && csr_ready) bytes_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         cmd_ff <= req_command;
         idx_ff <= idx_x;
         len_ff <= len_x;
         end_ff <= end_x;
         used_ff <= used_now;
         cnt_ff <= '0;
         pos_ff <= '0;
         case (cmd_type'(req_command))
            CMD_SET, CMD_CLR: begin
               st_ff <= (idx_x >= used_now) ? ST_RANGE : ST_OK;
               waddr_ff <= AW'(idx_x >> BW);
            end
            CMD_FIND: begin st_ff <= ST_NONE; waddr_ff <= '0; end
            CMD_FRUN: begin
               st_ff <= (len_x == '0) ? ST_RANGE : ST_NONE;
               waddr_ff <= '0;
            end
            CMD_MARK, CMD_CRUN, CMD_CHECK: begin
               st_ff <= (len_x == '0 || end_x > used_now) ? ST_RANGE : ST_OK;
               waddr_ff <= AW'(idx_x >> BW);
            end
            default: begin st_ff <= ST_RANGE; waddr_ff <= '0; end
         endcase
      end else if (state_ff == S_READ) begin
         if (used_ff == '0 && (cmd_ff == CMD_FIND || cmd_ff == CMD_FRUN) &&
             st_ff != ST_RANGE) st_ff <= ST_NONE;
      end else if (state_ff == S_WORK) begin
         st_ff <= st_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         waddr_ff <= waddr_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_start_lost: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> busy)
      else $error("command not taken");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");
   a_no_write_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WORK && cmd_ff == CMD_CHECK) |-> !wr_en)
      else $error("check command wrote the bitmap");
`endif
endmodule
`default_nettype wire
